>>> rtl/core/midi_track_note_extractor_macros.svh
// ----------------------------------------------------------------------------
// midi_track_note_extractor_macros
// Assertion macros used by the note extractor RTL.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_NOTE_EXTRACTOR_MACROS_SVH
`define MIDI_TRACK_NOTE_EXTRACTOR_MACROS_SVH
// Implication checked at every rising edge outside reset.
`define MTNE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define MTNE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/core/mtne_pkg.sv
// ----------------------------------------------------------------------------
// mtne_pkg
// Types and constants shared by the MIDI track note extractor.
// ----------------------------------------------------------------------------
`default_nettype none
package mtne_pkg;

  localparam int unsigned OpenNoteDepth = 16;

  typedef enum logic [3:0] {
    PH_IDLE, PH_MAGIC, PH_LEN, PH_DELTA, PH_STATUS, PH_NOTE_D1, PH_NOTE_D2,
    PH_META_TYPE, PH_META_LEN, PH_META_DATA, PH_SYS_LEN, PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NOTE = 2'd0, KIND_TEMPO = 2'd1, KIND_END = 2'd2, KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_MAGIC = 2'd1, ERR_STATUS = 2'd2, ERR_FULL = 2'd3
  } err_e;

  // One open note.
  typedef struct packed {
    logic [3:0]  channel;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [31:0] start;
  } note_t;

  // Command broadcast from the parser to every table cell.
  typedef struct packed {
    logic       clear;   // discard every open note
    logic       push;    // append a note at the tail
    logic       remove;  // close the newest matching note
    logic [6:0] pitch;   // pitch searched by remove
    note_t      note;    // entry written by push
  } tbl_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/mtne_cell.sv
// ----------------------------------------------------------------------------
// mtne_cell
// One slot of the ordered open-note table.
// ----------------------------------------------------------------------------
`default_nettype none
module mtne_cell import mtne_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire tbl_cmd_t cmd_i,
  input  wire logic     is_tail_i,   // this slot is the first free one
  input  wire logic     hit_above_i, // a newer slot matches the pitch
  input  wire logic     nb_valid_i,  // neighbor above holds a note
  input  wire note_t    nb_note_i,
  output logic          valid_o,
  output note_t         note_o,
  output logic          match_o,     // this slot matches the pitch
  output logic          hit_o        // this or a newer slot matches
);

  logic  valid_q, valid_d;
  note_t note_q, note_d;
  logic  shift;

  assign match_o = valid_q && (note_q.pitch == cmd_i.pitch);
  assign hit_o   = match_o || hit_above_i;
  // A remove is only issued when some slot matches, so the slots at or above
  // the newest match are exactly those with no match above them. They close
  // the gap by taking their neighbor.
  assign shift   = cmd_i.remove && !hit_above_i;

  always_comb begin
    valid_d = valid_q;
    note_d  = note_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.push && is_tail_i) begin
      valid_d = 1'b1;
      note_d  = cmd_i.note;
    end else if (shift) begin
      valid_d = nb_valid_i;
      note_d  = nb_note_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q <= note_d;
  end

  assign valid_o = valid_q;
  assign note_o  = note_q;

endmodule
`default_nettype wire

>>> rtl/core/mtne_table.sv
// ----------------------------------------------------------------------------
// mtne_table
// Chain of cells holding open notes, oldest at slot zero.
// ----------------------------------------------------------------------------
`default_nettype none
module mtne_table import mtne_pkg::*; #(
  parameter int unsigned Depth = OpenNoteDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire tbl_cmd_t cmd_i,
  output logic          full_o,
  output logic          found_o,
  output note_t         found_note_o
);

  logic  [Depth-1:0] valid;
  logic  [Depth-1:0] match;
  logic  [Depth:0]   hit;
  note_t             note [Depth];
  note_t             pick [Depth+1];

  assign hit[Depth]  = 1'b0;
  assign pick[Depth] = '0;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic  tail;
    logic  nb_valid;
    note_t nb_note;
    if (g == 0) begin : g_first
      assign tail = !valid[0];
    end else begin : g_rest
      assign tail = valid[g-1] && !valid[g];
    end
    if (g == Depth - 1) begin : g_top
      assign nb_valid = 1'b0;
      assign nb_note  = '0;
    end else begin : g_mid
      assign nb_valid = valid[g+1];
      assign nb_note  = note[g+1];
    end
    mtne_cell u_cell (
      .clk_i, .rst_ni, .cmd_i,
      .is_tail_i(tail), .hit_above_i(hit[g+1]),
      .nb_valid_i(nb_valid), .nb_note_i(nb_note),
      .valid_o(valid[g]), .note_o(note[g]),
      .match_o(match[g]), .hit_o(hit[g])
    );
    // Newest match wins: a slot only passes its own note if none above hit.
    assign pick[g] = (match[g] && !hit[g+1]) ? note[g] : pick[g+1];
  end

  assign full_o       = valid[Depth-1];
  assign found_o      = hit[0];
  assign found_note_o = pick[0];

endmodule
`default_nettype wire

>>> rtl/core/midi_track_note_extractor.sv
// ----------------------------------------------------------------------------
// midi_track_note_extractor
// Byte-serial MIDI track chunk parser that reports completed notes and tempo.
// ----------------------------------------------------------------------------
// Each byte is parsed in the cycle it is accepted, and its result, if any, is
// registered for the output at that same edge. The next byte is held off
// while busy_q is set, so the open-note chain can close its gap first.
// A result appears in the cycle after its byte and is held while the output
// is stalled.
// Reset clears the parser state, the table valid bits and the output valid.
`default_nettype none
`include "midi_track_note_extractor_macros.svh"
module midi_track_note_extractor import mtne_pkg::*; #(
  parameter int unsigned OPEN_NOTE_DEPTH = OpenNoteDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        track_start_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [1:0]       error_code_o,
  output logic [3:0]       channel_o,
  output logic [6:0]       pitch_o,
  output logic [6:0]       velocity_o,
  output logic [31:0]      start_tick_o,
  output logic [31:0]      duration_ticks_o,
  output logic [23:0]      tempo_usec_o
);

  localparam logic [7:0] MagicM = 8'h4D;
  localparam logic [7:0] MagicT = 8'h54;
  localparam logic [7:0] MagicR = 8'h72;
  localparam logic [7:0] MagicK = 8'h6B;
  localparam logic [7:0] StMeta = 8'hFF;
  localparam logic [7:0] StSysx = 8'hF0;
  localparam logic [7:0] StEsc  = 8'hF7;
  localparam logic [7:0] MetaEot = 8'h2F;
  localparam logic [7:0] MetaTempo = 8'h51;

  phase_e      phase_q, phase_d;
  logic [1:0]  midx_q, midx_d;
  logic [31:0] left_q, left_d;
  logic [27:0] vlq_q, vlq_d;
  logic [31:0] tick_q, tick_d;
  logic [7:0]  status_q, status_d;
  logic [6:0]  d1_q, d1_d;
  logic [7:0]  meta_q, meta_d;
  logic [27:0] skip_q, skip_d;
  logic [23:0] tempo_q, tempo_d;
  logic        busy_q;  // spare cycle after a byte for the table chain

  logic        res_v;
  logic [1:0]  res_kind, res_err;
  logic [3:0]  res_ch;
  logic [6:0]  res_pitch, res_vel;
  logic [31:0] res_start, res_dur;
  logic [23:0] res_tempo;

  logic        ov_q;
  logic [1:0]  ok_q, oe_q;
  logic [3:0]  och_q;
  logic [6:0]  op_q, ovel_q;
  logic [31:0] ost_q, odur_q;
  logic [23:0] otp_q;

  tbl_cmd_t    cmd;
  logic        full, found;
  note_t       fnote;

  // A byte is taken when the spare cycle is over and the output slot is free.
  logic take;
  assign in_stall_o = busy_q || (ov_q && out_stall_i);
  assign take       = in_valid_i && !in_stall_o;

  mtne_table #(.Depth(OPEN_NOTE_DEPTH)) u_table (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .full_o(full), .found_o(found), .found_note_o(fnote)
  );

  logic [7:0]  b;
  logic [27:0] vlq_next;
  logic [31:0] left_dec;
  logic [27:0] skip_dec;
  assign b        = data_byte_i;
  assign vlq_next = {vlq_q[20:0], b[6:0]};
  assign left_dec = left_q - 32'd1;
  assign skip_dec = skip_q - 28'd1;

  always_comb begin
    phase_d  = phase_q;
    midx_d   = midx_q;
    left_d   = left_q;
    vlq_d    = vlq_q;
    tick_d   = tick_q;
    status_d = status_q;
    d1_d     = d1_q;
    meta_d   = meta_q;
    skip_d   = skip_q;
    tempo_d  = tempo_q;
    res_v    = 1'b0;
    res_kind = KIND_NOTE;
    res_err  = ERR_NONE;
    res_ch   = '0;
    res_pitch = '0;
    res_vel  = '0;
    res_start = '0;
    res_dur  = '0;
    res_tempo = '0;
    cmd      = '0;
    cmd.pitch = d1_q;
    cmd.note  = '{channel: status_q[3:0], pitch: d1_q, velocity: b[6:0], start: tick_q};

    if (take) begin
      phase_e ph;
      ph = phase_q;
      if (track_start_i) begin
        cmd.clear = 1'b1;
        tick_d = '0;
        left_d = '0;
        vlq_d  = '0;
        midx_d = '0;
        ph     = PH_MAGIC;
        phase_d = PH_MAGIC;
      end
      unique case (ph)
        PH_IDLE: ;
        PH_MAGIC: begin
          logic [7:0] exp_b;
          unique case (midx_d)
            2'd0: exp_b = MagicM;
            2'd1: exp_b = MagicT;
            2'd2: exp_b = MagicR;
            default: exp_b = MagicK;
          endcase
          if (b != exp_b) begin
            phase_d = PH_IDLE;
            cmd.clear = 1'b1;
            res_v = 1'b1; res_kind = KIND_ERROR; res_err = ERR_MAGIC;
          end else if (midx_d == 2'd3) begin
            midx_d = '0;
            left_d = '0;
            phase_d = PH_LEN;
          end else begin
            midx_d = midx_d + 2'd1;
          end
        end
        PH_LEN: begin
          left_d = {left_q[23:0], b};
          if (midx_q == 2'd3) begin
            midx_d = '0;
            if ({left_q[23:0], b} == 32'd0) begin
              phase_d = PH_IDLE;
              cmd.clear = 1'b1;
              res_v = 1'b1; res_kind = KIND_END;
            end else begin
              vlq_d = '0;
              phase_d = PH_DELTA;
            end
          end else begin
            midx_d = midx_q + 2'd1;
          end
        end
        default: begin
          left_d = left_dec;
          unique case (ph)
            PH_DELTA: begin
              vlq_d = vlq_next;
              if (!b[7]) begin
                tick_d = tick_q + {4'd0, vlq_next};
                vlq_d = '0;
                phase_d = PH_STATUS;
              end
            end
            PH_STATUS: begin
              status_d = b;
              if (!b[7]) begin
                phase_d = PH_IDLE;
                cmd.clear = 1'b1;
                res_v = 1'b1; res_kind = KIND_ERROR; res_err = ERR_STATUS;
              end else if (b == StMeta) begin
                phase_d = PH_META_TYPE;
              end else if (b == StSysx || b == StEsc) begin
                vlq_d = '0;
                phase_d = PH_SYS_LEN;
              end else if (b[7:4] == 4'hF) begin
                if (b == 8'hF2) begin
                  skip_d = 28'd2; phase_d = PH_SKIP;
                end else if (b == 8'hF1 || b == 8'hF3) begin
                  skip_d = 28'd1; phase_d = PH_SKIP;
                end else begin
                  vlq_d = '0; phase_d = PH_DELTA;
                end
              end else if (b[7:4] == 4'h8 || b[7:4] == 4'h9) begin
                phase_d = PH_NOTE_D1;
              end else begin
                skip_d = (b[7:4] == 4'hC || b[7:4] == 4'hD) ? 28'd1 : 28'd2;
                phase_d = PH_SKIP;
              end
            end
            PH_NOTE_D1: begin
              d1_d = b[6:0];
              phase_d = PH_NOTE_D2;
            end
            PH_NOTE_D2: begin
              vlq_d = '0;
              phase_d = PH_DELTA;
              if (status_q[7:4] == 4'h9 && b[6:0] != 7'd0) begin
                if (full) begin
                  res_v = 1'b1; res_kind = KIND_ERROR; res_err = ERR_FULL;
                end else begin
                  cmd.push = 1'b1;
                end
              end else if (found) begin
                cmd.remove = 1'b1;
                res_v = 1'b1; res_kind = KIND_NOTE;
                res_ch = fnote.channel;
                res_pitch = fnote.pitch;
                res_vel = fnote.velocity;
                res_start = fnote.start;
                res_dur = tick_q - fnote.start;
              end
            end
            PH_META_TYPE: begin
              meta_d = b;
              if (b == MetaEot) begin
                phase_d = PH_IDLE;
                cmd.clear = 1'b1;
                res_v = 1'b1; res_kind = KIND_END;
              end else begin
                vlq_d = '0;
                phase_d = PH_META_LEN;
              end
            end
            PH_META_LEN: begin
              vlq_d = vlq_next;
              if (!b[7]) begin
                if (vlq_next == '0) begin
                  vlq_d = '0; phase_d = PH_DELTA;
                end else begin
                  skip_d = vlq_next;
                  tempo_d = '0;
                  phase_d = PH_META_DATA;
                end
              end
            end
            PH_META_DATA: begin
              tempo_d = {tempo_q[15:0], b};
              skip_d = skip_dec;
              if (skip_dec == '0) begin
                vlq_d = '0; phase_d = PH_DELTA;
                if (meta_q == MetaTempo) begin
                  res_v = 1'b1; res_kind = KIND_TEMPO;
                  res_tempo = {tempo_q[15:0], b};
                end
              end
            end
            PH_SYS_LEN: begin
              vlq_d = vlq_next;
              if (!b[7]) begin
                if (vlq_next == '0) begin
                  vlq_d = '0; phase_d = PH_DELTA;
                end else begin
                  skip_d = vlq_next; phase_d = PH_SKIP;
                end
              end
            end
            PH_SKIP: begin
              skip_d = skip_dec;
              if (skip_dec == '0) begin
                vlq_d = '0; phase_d = PH_DELTA;
              end
            end
            default: begin
              phase_d = PH_IDLE;
              cmd.clear = 1'b1;
            end
          endcase
          // Byte count exhausted ends the track after this byte.
          if (phase_d != PH_IDLE && left_dec == '0) begin
            phase_d = PH_IDLE;
            cmd.clear = 1'b1;
            cmd.push = 1'b0;
            if (!res_v) begin
              res_v = 1'b1; res_kind = KIND_END; res_err = ERR_NONE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      midx_q <= '0; left_q <= '0; vlq_q <= '0; tick_q <= '0;
      status_q <= '0; d1_q <= '0; meta_q <= '0; skip_q <= '0; tempo_q <= '0;
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      midx_q <= midx_d; left_q <= left_d; vlq_q <= vlq_d; tick_q <= tick_d;
      status_q <= status_d; d1_q <= d1_d; meta_q <= meta_d;
      skip_q <= skip_d; tempo_q <= tempo_d;
      busy_q <= take;
      if (take) begin
        ov_q <= res_v;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ok_q <= res_kind; oe_q <= res_err; och_q <= res_ch; op_q <= res_pitch;
      ovel_q <= res_vel; ost_q <= res_start; odur_q <= res_dur; otp_q <= res_tempo;
    end
  end

  assign out_valid_o      = ov_q;
  assign result_kind_o    = ok_q;
  assign error_code_o     = oe_q;
  assign channel_o        = och_q;
  assign pitch_o          = op_q;
  assign velocity_o       = ovel_q;
  assign start_tick_o     = ost_q;
  assign duration_ticks_o = odur_q;
  assign tempo_usec_o     = otp_q;

  `MTNE_ASSERT_NXT(a_spare_cycle, take, in_stall_o, "byte taken without spare cycle")
  `MTNE_ASSERT_IMP(a_no_take_full, ov_q && out_stall_i, !take, "byte taken over held result")
  `MTNE_ASSERT_NXT(a_idle_clears, take && res_v && phase_d == PH_IDLE,
    !u_table.found_o, "table not cleared at track end")
  `MTNE_ASSERT_IMP(a_err_kind, ov_q && oe_q != ERR_NONE, ok_q == KIND_ERROR,
    "error code on non-error result")

endmodule
`default_nettype wire

>>> sim/midi_track_note_extractor_tb.sv
// ----------------------------------------------------------------------------
// midi_track_note_extractor_tb
// Self-checking testbench that feeds MIDI track bytes and checks each result.
// ----------------------------------------------------------------------------
// The bench holds its own model of the track parser. Every byte accepted by
// the block is run through that model, and any result it yields is queued.
// Each result transaction from the block is compared field by field with the
// oldest queued result. Directed tracks cover the special cases, and random
// tracks are mostly well-formed, with some noise and some broken tracks.
// The sender and the receiver idle at random in several phases.
`default_nettype none
module midi_track_note_extractor_tb;
  import mtne_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        track_start_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  result_kind_o;
  logic [1:0]  error_code_o;
  logic [3:0]  channel_o;
  logic [6:0]  pitch_o;
  logic [6:0]  velocity_o;
  logic [31:0] start_tick_o;
  logic [31:0] duration_ticks_o;
  logic [23:0] tempo_usec_o;

  midi_track_note_extractor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .track_start_i    (track_start_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .error_code_o     (error_code_o),
    .channel_o        (channel_o),
    .pitch_o          (pitch_o),
    .velocity_o       (velocity_o),
    .start_tick_o     (start_tick_o),
    .duration_ticks_o (duration_ticks_o),
    .tempo_usec_o     (tempo_usec_o)
  );

  // One result as the block reports it.
  typedef struct packed {
    kind_e       kind;
    err_e        err;
    logic [3:0]  channel;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [31:0] start;
    logic [31:0] duration;
    logic [23:0] tempo;
  } track_event_t;

  localparam logic [7:0] MetaStatus  = 8'hFF;
  localparam logic [7:0] MetaEnd     = 8'h2F;
  localparam logic [7:0] MetaTempo   = 8'h51;
  localparam logic [7:0] SysexStatus = 8'hF0;
  localparam logic [7:0] SysexEscape = 8'hF7;
  localparam logic [7:0] NoteOnHi    = 8'h90;
  localparam logic [7:0] NoteOffHi   = 8'h80;
  localparam int unsigned SettleCycles = 8;

  // Idling phases: percentage of cycles in which each side holds off.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned events_seen;
  int unsigned notes_seen;

  track_event_t pending_events[$];

  // Model state of the parser.
  phase_e      m_phase;
  logic [1:0]  m_magic_idx;
  logic [31:0] m_bytes_left;
  logic [27:0] m_vlq;
  logic [31:0] m_tick;
  logic [7:0]  m_status;
  logic [6:0]  m_first_data;
  logic [7:0]  m_meta_kind;
  logic [27:0] m_skip;
  logic [23:0] m_tempo;
  note_t       m_notes[OpenNoteDepth];
  int unsigned m_count;

  // Track bytes built by the generators before they are sent.
  logic [7:0] track_buf[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #80000000;
    $display("status: fail");
    $finish;
  end

  function automatic track_event_t make_event(kind_e kind, err_e err);
    track_event_t ev;
    ev = '0;
    ev.kind = kind;
    ev.err = err;
    return ev;
  endfunction

  // Feeds one byte of a variable-length quantity; returns 1 when complete.
  function automatic bit vlq_take(logic [7:0] b);
    m_vlq = {m_vlq[20:0], b[6:0]};
    return !b[7];
  endfunction

  function automatic void restart_delta();
    m_vlq = '0;
    m_phase = PH_DELTA;
  endfunction

  function automatic void begin_skip(logic [27:0] n);
    if (n == 0) begin
      restart_delta();
    end else begin
      m_skip = n;
      m_phase = PH_SKIP;
    end
  endfunction

  // Opens or closes a note after its second data byte.
  function automatic bit apply_note(logic [6:0] vel, output track_event_t ev);
    ev = '0;
    if (m_status[7:4] == NoteOnHi[7:4] && vel != 0) begin
      if (m_count >= OpenNoteDepth) begin
        ev = make_event(KIND_ERROR, ERR_FULL);
        return 1'b1;
      end
      m_notes[m_count] = {m_status[3:0], m_first_data, vel, m_tick};
      m_count++;
      return 1'b0;
    end
    for (int k = int'(m_count) - 1; k >= 0; k--) begin
      if (m_notes[k].pitch == m_first_data) begin
        ev = make_event(KIND_NOTE, ERR_NONE);
        ev.channel = m_notes[k].channel;
        ev.pitch = m_notes[k].pitch;
        ev.velocity = m_notes[k].velocity;
        ev.start = m_notes[k].start;
        ev.duration = m_tick - m_notes[k].start;
        for (int j = k; j < int'(m_count) - 1; j++) m_notes[j] = m_notes[j + 1];
        m_count--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Handles one byte of the chunk body.
  function automatic bit parse_body(logic [7:0] b, output track_event_t ev);
    ev = '0;
    case (m_phase)
      PH_DELTA: begin
        if (vlq_take(b)) begin
          m_tick += 32'(m_vlq);
          m_vlq = '0;
          m_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        m_status = b;
        if (!b[7]) begin
          m_phase = PH_IDLE;
          m_count = 0;
          ev = make_event(KIND_ERROR, ERR_STATUS);
          return 1'b1;
        end
        if (b == MetaStatus) m_phase = PH_META_TYPE;
        else if (b == SysexStatus || b == SysexEscape) begin
          m_vlq = '0;
          m_phase = PH_SYS_LEN;
        end else if (b >= 8'hF0) begin
          begin_skip(b == 8'hF2 ? 28'd2 : (b == 8'hF1 || b == 8'hF3) ? 28'd1 : 28'd0);
        end else if (b[7:4] == NoteOffHi[7:4] || b[7:4] == NoteOnHi[7:4]) begin
          m_phase = PH_NOTE_D1;
        end else begin
          begin_skip((b[7:4] == 4'hC || b[7:4] == 4'hD) ? 28'd1 : 28'd2);
        end
      end
      PH_NOTE_D1: begin
        m_first_data = b[6:0];
        m_phase = PH_NOTE_D2;
      end
      PH_NOTE_D2: begin
        restart_delta();
        return apply_note(b[6:0], ev);
      end
      PH_META_TYPE: begin
        m_meta_kind = b;
        if (b == MetaEnd) begin
          m_phase = PH_IDLE;
          m_count = 0;
          ev = make_event(KIND_END, ERR_NONE);
          return 1'b1;
        end
        m_vlq = '0;
        m_phase = PH_META_LEN;
      end
      PH_META_LEN: begin
        if (vlq_take(b)) begin
          if (m_vlq == 0) restart_delta();
          else begin
            m_skip = m_vlq;
            m_tempo = '0;
            m_phase = PH_META_DATA;
          end
        end
      end
      PH_META_DATA: begin
        m_tempo = {m_tempo[15:0], b};
        m_skip = m_skip - 28'd1;
        if (m_skip == 0) begin
          restart_delta();
          if (m_meta_kind == MetaTempo) begin
            ev = make_event(KIND_TEMPO, ERR_NONE);
            ev.tempo = m_tempo;
            return 1'b1;
          end
        end
      end
      PH_SYS_LEN: begin
        if (vlq_take(b)) begin_skip(m_vlq);
      end
      PH_SKIP: begin
        m_skip = m_skip - 28'd1;
        if (m_skip == 0) restart_delta();
      end
      default: begin
        m_phase = PH_IDLE;
        m_count = 0;
      end
    endcase
    return 1'b0;
  endfunction

  // Advances the track parser model by one accepted byte.
  function automatic bit track_parse(logic [7:0] b, logic start, output track_event_t ev);
    logic [7:0] magic[4];
    bit got;
    magic = '{8'h4D, 8'h54, 8'h72, 8'h6B};
    ev = '0;
    if (start) begin
      m_count = 0;
      m_tick = '0;
      m_bytes_left = '0;
      m_vlq = '0;
      m_magic_idx = '0;
      m_phase = PH_MAGIC;
    end
    case (m_phase)
      PH_IDLE: return 1'b0;
      PH_MAGIC: begin
        if (b != magic[m_magic_idx]) begin
          m_phase = PH_IDLE;
          m_count = 0;
          ev = make_event(KIND_ERROR, ERR_MAGIC);
          return 1'b1;
        end
        if (m_magic_idx == 2'd3) begin
          m_magic_idx = '0;
          m_bytes_left = '0;
          m_phase = PH_LEN;
        end else m_magic_idx++;
        return 1'b0;
      end
      PH_LEN: begin
        m_bytes_left = {m_bytes_left[23:0], b};
        if (m_magic_idx == 2'd3) begin
          m_magic_idx = '0;
          if (m_bytes_left == 0) begin
            m_phase = PH_IDLE;
            m_count = 0;
            ev = make_event(KIND_END, ERR_NONE);
            return 1'b1;
          end
          restart_delta();
        end else m_magic_idx++;
        return 1'b0;
      end
      default: begin
        m_bytes_left--;
        got = parse_body(b, ev);
        // The byte count running out ends the track as well.
        if (m_phase != PH_IDLE && m_bytes_left == 0) begin
          m_phase = PH_IDLE;
          m_count = 0;
          if (!got) begin
            ev = make_event(KIND_END, ERR_NONE);
            got = 1'b1;
          end
        end
        return got;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Sends one byte and updates the model when the transaction is accepted.
  // Valid stays high after an accepted byte so that bytes can follow back to
  // back; the sender drops it only when it idles or drains.
  task automatic send_byte(logic [7:0] b, logic start);
    track_event_t ev;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    track_start_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (track_parse(b, start, ev)) pending_events.push_back(ev);
    bytes_sent++;
  endtask

  // Sends the buffered track, with track_start on its first byte.
  task automatic send_track();
    foreach (track_buf[i]) send_byte(track_buf[i], i == 0);
    track_buf.delete();
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Result checker, sampling at the rising edge where a transaction completes.
  initial begin
    track_event_t want;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        events_seen++;
        if (pending_events.size() == 0) begin
          report_mismatch("unexpected result kind", 32'(result_kind_o), 32'd0);
        end else begin
          want = pending_events.pop_front();
          if (want.kind == KIND_NOTE) notes_seen++;
          if (result_kind_o != want.kind)
            report_mismatch("kind", 32'(result_kind_o), 32'(want.kind));
          if (error_code_o != want.err)
            report_mismatch("error", 32'(error_code_o), 32'(want.err));
          if (channel_o != want.channel)
            report_mismatch("channel", 32'(channel_o), 32'(want.channel));
          if (pitch_o != want.pitch)
            report_mismatch("pitch", 32'(pitch_o), 32'(want.pitch));
          if (velocity_o != want.velocity)
            report_mismatch("velocity", 32'(velocity_o), 32'(want.velocity));
          if (start_tick_o != want.start) report_mismatch("start", start_tick_o, want.start);
          if (duration_ticks_o != want.duration)
            report_mismatch("duration", duration_ticks_o, want.duration);
          if (tempo_usec_o != want.tempo)
            report_mismatch("tempo", 32'(tempo_usec_o), 32'(want.tempo));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Track building helpers.
  function automatic void put_header(logic [31:0] len);
    track_buf.push_back(8'h4D);
    track_buf.push_back(8'h54);
    track_buf.push_back(8'h72);
    track_buf.push_back(8'h6B);
    for (int i = 3; i >= 0; i--) track_buf.push_back(len[i*8 +: 8]);
  endfunction

  function automatic void put_vlq(logic [27:0] v);
    logic [7:0] grp[$];
    grp.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      grp.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    foreach (grp[i]) track_buf.push_back(grp[i]);
  endfunction

  // Patches the length field with the true body size.
  function automatic void fix_length();
    logic [31:0] len;
    len = track_buf.size() - 8;
    for (int i = 0; i < 4; i++) track_buf[4 + i] = len[(3 - i)*8 +: 8];
  endfunction

  function automatic void put_note(logic [27:0] dt, logic [7:0] st, logic [7:0] p,
                                   logic [7:0] v);
    put_vlq(dt);
    track_buf.push_back(st);
    track_buf.push_back(p);
    track_buf.push_back(v);
  endfunction

  function automatic void put_meta(logic [27:0] dt, logic [7:0] kind, int unsigned n);
    put_vlq(dt);
    track_buf.push_back(MetaStatus);
    track_buf.push_back(kind);
    put_vlq(28'(n));
    repeat (n) track_buf.push_back(8'($urandom));
  endfunction

  task automatic test_directed_edges();
    // Idle bytes before any track start give nothing.
    send_byte(8'h4D, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Bad magic on the second byte.
    send_byte(8'h4D, 1'b1);
    send_byte(8'h00, 1'b0);
    // Zero length reports end of track on the last length byte.
    put_header(0);
    send_track();
    // A note with high-bit data bytes, a tempo, and an explicit end.
    put_header(0);
    put_note(28'hFFFFFFF, 8'h9F, 8'hFF, 8'hFF);
    put_note(0, 8'h93, 8'h00, 8'h01);
    put_note(5, 8'h80, 8'h7F, 8'h00);
    put_note(1, 8'h90, 8'h00, 8'h00);
    put_meta(3, MetaTempo, 3);
    put_meta(0, MetaTempo, 0);
    put_meta(0, MetaTempo, 5);
    put_vlq(0);
    track_buf.push_back(MetaStatus);
    track_buf.push_back(MetaEnd);
    fix_length();
    track_buf.push_back(8'h12);
    send_track();
    // Missing status byte.
    put_header(100);
    put_vlq(1);
    track_buf.push_back(8'h40);
    send_track();
    drain();
  endtask

  task automatic test_directed_table_full();
    put_header(0);
    for (int i = 0; i <= OpenNoteDepth; i++) put_note(1, 8'h90, 8'(i), 8'd64);
    for (int i = 0; i < 4; i++) put_note(0, 8'h80, 8'(i), 8'd0);
    // Sysex, system, and other channel messages are skipped by length.
    put_vlq(0);
    track_buf.push_back(SysexStatus);
    put_vlq(2);
    track_buf.push_back(8'h90);
    track_buf.push_back(8'h11);
    put_vlq(0);
    track_buf.push_back(8'hF2);
    track_buf.push_back(8'h01);
    track_buf.push_back(8'h02);
    put_vlq(0);
    track_buf.push_back(8'hC3);
    track_buf.push_back(8'h05);
    put_note(0, 8'h80, 8'd5, 8'd0);
    fix_length();
    send_track();
    drain();
  endtask

  // Builds one random track: mostly well formed, sometimes noisy or cut short.
  function automatic void build_random_track();
    int unsigned events;
    int unsigned pick;
    logic [6:0] open_p[$];
    events = $urandom_range(3, 20);
    put_header(0);
    for (int e = 0; e < events; e++) begin
      pick = $urandom_range(99);
      if (pick < 40 || open_p.size() == 0) begin
        open_p.push_back(7'($urandom_range(open_p.size() < 3 ? 127 : 12)));
        put_note($urandom_range(3) == 0 ? 28'($urandom) : 28'($urandom_range(200)),
                 {4'h9, 4'($urandom)}, {1'($urandom), open_p[$]}, 8'($urandom_range(1, 255)));
      end else if (pick < 75) begin
        put_note(28'($urandom_range(300)), $urandom_range(1) ? {4'h8, 4'($urandom)}
                 : {4'h9, 4'($urandom)}, {1'b0, open_p[$urandom_range(open_p.size() - 1)]},
                 $urandom_range(1) ? 8'($urandom) : 8'h00);
      end else if (pick < 83) begin
        put_meta(28'($urandom_range(50)), MetaTempo, $urandom_range(0, 5));
      end else if (pick < 88) begin
        put_meta(28'($urandom_range(50)), 8'($urandom_range(0, 127)), $urandom_range(0, 4));
      end else if (pick < 94) begin
        put_vlq(28'($urandom_range(9)));
        track_buf.push_back({4'($urandom_range(10, 15)), 4'($urandom)});
        repeat ($urandom_range(0, 2)) track_buf.push_back(8'($urandom_range(127)));
        if (track_buf[$] >= 8'hF0) track_buf.pop_back();
      end else begin
        put_vlq(28'($urandom_range(9)));
        track_buf.push_back(SysexStatus);
        put_vlq(28'($urandom_range(3)));
        repeat (3) track_buf.push_back(8'($urandom));
      end
    end
    if ($urandom_range(1)) begin
      put_vlq(0);
      track_buf.push_back(MetaStatus);
      track_buf.push_back(MetaEnd);
    end
    fix_length();
    // Occasionally cut the length short, break a byte, or pad with noise.
    pick = $urandom_range(99);
    if (pick < 10) track_buf[7] = 8'($urandom_range(1, track_buf.size() - 8));
    else if (pick < 15) track_buf[$urandom_range(8, track_buf.size() - 1)] = 8'($urandom);
    else if (pick < 18) track_buf[$urandom_range(0, 3)] = 8'($urandom);
    else if (pick < 20) track_buf[$urandom_range(4, 7)] = 8'($urandom);
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 4)) track_buf.push_back(8'($urandom));
  endfunction

  task automatic test_random_tracks(int unsigned n_bytes);
    int unsigned target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      build_random_track();
      send_track();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    track_start_i = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    bytes_sent = 0;
    events_seen = 0;
    notes_seen = 0;
    m_phase = PH_IDLE;
    m_magic_idx = '0;
    m_bytes_left = '0;
    m_vlq = '0;
    m_tick = '0;
    m_status = '0;
    m_first_data = '0;
    m_meta_kind = '0;
    m_skip = '0;
    m_tempo = '0;
    m_count = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_directed_table_full();
    test_random_tracks(400);
    // Hold off until every expected result has arrived.
    drain();
    send_idle_pct = 70;
    test_random_tracks(400);
    send_idle_pct = 0;
    recv_stall_pct = 70;
    test_random_tracks(400);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    test_random_tracks(400);
    drain();
    $display("covered %0d bytes, %0d results, %0d completed notes", bytes_sent,
             events_seen, notes_seen);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/mtne_pkg.sv
rtl/core/mtne_cell.sv
rtl/core/mtne_table.sv
rtl/core/midi_track_note_extractor.sv
sim/midi_track_note_extractor_tb.sv
